### design/qse_pkg.sv
package qse_pkg;
   localparam int ITEMS = 64;
   localparam int IDX_W = $clog2(ITEMS);
   localparam int CNT_W = IDX_W + 1;
   localparam int VAL_W = 32;
   localparam int STK_W = 2 * IDX_W;
   localparam int STK_DEPTH = ITEMS;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic last;
   } req_word_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] sorted_value;
      logic end_of_batch;
      logic overflow;
   } rsp_word_type;

   function automatic logic le_signed(logic signed [VAL_W-1:0] a,
                                      logic signed [VAL_W-1:0] b);
      return a <= b;
   endfunction
endpackage

### design/qse_stream_if.sv
interface qse_req_if;
   logic valid;
   logic ready;
   qse_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface qse_rsp_if;
   logic valid;
   logic ready;
   qse_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/quicksort_engine_unit.sv
// Load accepts words until the one marked last; the sort then reads element memory for
// each comparison, writes it twice per swap, partitions each range it can split and skips
// ranges too short to split; the batch then streams out, each word held until it is taken.
// One batch at a time; one element memory read per comparison sets the pace.
// Reset: synchronous, active high; clears the word count, flags, stack pointer and FSM.
module quicksort_engine_unit (
   input logic clock,
   input logic reset,
   qse_req_if.sink req,
   qse_rsp_if.source rsp
);
   localparam int IW = qse_pkg::IDX_W;
   localparam int CW = qse_pkg::CNT_W;
   localparam int VW = qse_pkg::VAL_W;
   localparam int SW = qse_pkg::STK_W;

   typedef enum logic [4:0] {
      S_LOAD, S_POP, S_POPW, S_RANGE, S_PIVW, S_PIV,
      S_IRD, S_IW, S_IT, S_JRD, S_JW, S_JT,
      S_SW1, S_SW2, S_SW3, S_FRD, S_FW, S_FIN,
      S_PUSH2, S_ORD, S_OW, S_OUT
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic drop_ff;
   logic [CW-1:0] sp_ff;
   logic [IW-1:0] lo_ff, hi_ff, i_ff, j_ff, k_ff;
   logic signed [VW-1:0] pivot_ff, ival_ff, tmp_ff;
   logic first_ff;
   logic rsp_valid_ff;
   qse_pkg::rsp_word_type rsp_ff;

   logic e_we;
   logic [IW-1:0] e_wa, e_ra;
   logic [VW-1:0] e_wd, e_rd;
   logic s_we;
   logic [IW-1:0] s_wa, s_ra;
   logic [SW-1:0] s_wd, s_rd;
   logic signed [VW-1:0] e_val;

   assign e_val = e_rd;

   qse_ram #(.WIDTH(VW), .DEPTH(qse_pkg::ITEMS)) u_elem (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   qse_ram #(.WIDTH(SW), .DEPTH(qse_pkg::STK_DEPTH)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));

   assign req.ready = (state_ff == S_LOAD);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   logic accept;
   assign accept = req.valid && req.ready;

   always_comb begin
      e_we = 1'b0;
      e_wa = i_ff;
      e_wd = ival_ff;
      e_ra = i_ff;
      s_we = 1'b0;
      s_wa = sp_ff[IW-1:0];
      s_wd = {lo_ff, hi_ff};
      s_ra = IW'(sp_ff - CW'(1));
      unique case (state_ff)
         S_LOAD: begin
            e_we = accept && (count_ff < CW'(qse_pkg::ITEMS));
            e_wa = count_ff[IW-1:0];
            e_wd = req.data.value;
         end
         S_POP: s_ra = IW'(sp_ff - CW'(1));
         S_RANGE, S_PIVW: e_ra = lo_ff;
         S_IRD: e_ra = i_ff;
         S_JRD, S_JW: e_ra = j_ff;
         S_SW1: begin
            e_we = 1'b1; e_wa = i_ff; e_wd = tmp_ff;
         end
         S_SW2: begin
            e_we = 1'b1; e_wa = j_ff; e_wd = ival_ff;
         end
         S_FRD: e_ra = j_ff;
         S_FW: begin
            e_we = 1'b1; e_wa = lo_ff; e_wd = e_rd;
         end
         S_FIN: begin
            e_we = 1'b1; e_wa = j_ff; e_wd = pivot_ff;
            s_we = (j_ff > lo_ff + IW'(1)) && (sp_ff < CW'(qse_pkg::STK_DEPTH));
            s_wd = {lo_ff, IW'(j_ff - IW'(1))};
         end
         S_PUSH2: begin
            s_we = (first_ff || (CW'(j_ff) + CW'(1) < CW'(hi_ff)))
                   && (sp_ff < CW'(qse_pkg::STK_DEPTH));
            s_wd = first_ff ? {lo_ff, hi_ff} : {IW'(j_ff + IW'(1)), hi_ff};
         end
         S_ORD: e_ra = k_ff;
         S_OUT: e_ra = k_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff <= 1'b0;
         sp_ff <= '0;
         first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: if (accept) begin
               if (count_ff < CW'(qse_pkg::ITEMS)) count_ff <= count_ff + CW'(1);
               else drop_ff <= 1'b1;
               if (req.data.last) begin
                  sp_ff <= '0;
                  k_ff <= '0;
                  if (count_ff == '0) begin
                     state_ff <= S_ORD;
                  end else if (count_ff < CW'(qse_pkg::ITEMS)) begin
                     lo_ff <= '0; hi_ff <= count_ff[IW-1:0];
                     state_ff <= (count_ff >= CW'(1)) ? S_PUSH2 : S_ORD;
                     first_ff <= 1'b1;
                  end else begin
                     lo_ff <= '0; hi_ff <= IW'(qse_pkg::ITEMS - 1);
                     first_ff <= 1'b1;
                     state_ff <= S_PUSH2;
                  end
               end
            end
            S_PUSH2: begin
               if (s_we)
                  sp_ff <= sp_ff + CW'(1);
               first_ff <= 1'b0;
               state_ff <= S_POP;
            end
            S_POP: begin
               if (sp_ff == '0) begin
                  k_ff <= '0;
                  state_ff <= S_ORD;
               end else begin
                  sp_ff <= sp_ff - CW'(1);
                  state_ff <= S_POPW;
               end
            end
            S_POPW: begin
               lo_ff <= s_rd[SW-1:IW];
               hi_ff <= s_rd[IW-1:0];
               state_ff <= S_RANGE;
            end
            S_RANGE: begin
               if (lo_ff >= hi_ff) state_ff <= S_POP;
               else begin
                  i_ff <= lo_ff + IW'(1);
                  j_ff <= hi_ff;
                  state_ff <= S_PIVW;
               end
            end
            S_PIVW: state_ff <= S_PIV;
            S_PIV: begin
               pivot_ff <= e_val;
               state_ff <= S_IRD;
            end
            S_IRD: state_ff <= S_IW;
            S_IW: state_ff <= S_IT;
            S_IT: begin
               if (i_ff < hi_ff && qse_pkg::le_signed(e_val, pivot_ff)) begin
                  i_ff <= i_ff + IW'(1);
                  state_ff <= S_IRD;
               end else begin
                  ival_ff <= e_val;
                  state_ff <= S_JRD;
               end
            end
            S_JRD: state_ff <= S_JW;
            S_JW: state_ff <= S_JT;
            S_JT: begin
               if (j_ff > lo_ff && !qse_pkg::le_signed(e_val, pivot_ff)) begin
                  j_ff <= j_ff - IW'(1);
                  state_ff <= S_JRD;
               end else if (i_ff < j_ff) begin
                  tmp_ff <= e_val;
                  state_ff <= S_SW1;
               end else begin
                  state_ff <= S_FRD;
               end
            end
            S_SW1: state_ff <= S_SW2;
            S_SW2: begin
               i_ff <= i_ff + IW'(1);
               j_ff <= j_ff - IW'(1);
               state_ff <= S_IRD;
            end
            S_FRD: state_ff <= S_FW;
            S_FW: state_ff <= S_FIN;
            S_FIN: begin
               if (j_ff > lo_ff + IW'(1) && sp_ff < CW'(qse_pkg::STK_DEPTH))
                  sp_ff <= sp_ff + CW'(1);
               state_ff <= S_PUSH2;
            end
            S_ORD: begin
               if (count_ff == '0) begin
                  drop_ff <= 1'b0;
                  state_ff <= S_LOAD;
               end else state_ff <= S_OW;
            end
            S_OW: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.sorted_value <= e_val;
               rsp_ff.end_of_batch <= (CW'(k_ff) + CW'(1) == count_ff);
               rsp_ff.overflow <= drop_ff;
               k_ff <= k_ff + IW'(1);
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp.ready) begin
               rsp_valid_ff <= 1'b0;
               if (rsp_ff.end_of_batch) begin
                  count_ff <= '0;
                  drop_ff <= 1'b0;
                  sp_ff <= '0;
                  state_ff <= S_LOAD;
               end else state_ff <= S_OW;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> !req.ready) else $error("ready while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(qse_pkg::ITEMS)) else $error("count overrun");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("rsp dropped");
`endif
endmodule

### design/qse_ram.sv
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
